### design/stbs_pkg.sv
package stbs_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    // low and high+1 range over 0..TABLE_DEPTH
    localparam int SPAN_W      = ADDR_W + 1;
    localparam int SUM_W       = SPAN_W + 1;

    localparam int INDEX_W     = 10;
    localparam int VALUE_W     = 32;
    localparam int POS_W       = 10;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    typedef struct packed {
        logic start;          // search transfer accepted
        logic write;          // write transfer accepted
        logic step;           // probe data valid this cycle
        logic load_out;       // load output register
        logic out_from_held;  // output source is held result
        logic hold_result;    // park the final result
    } t_dp_cmd;

    typedef struct packed {
        logic done;           // current probe ends the search
    } t_dp_status;

endpackage

### design/stbs_ram.sv
module stbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/stbs_dp.sv
module stbs_dp
    import stbs_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [INDEX_W-1:0]        i_cfg_wdata,
    input  logic [INDEX_W-1:0]        i_index,
    input  logic signed [VALUE_W-1:0] i_value,
    input  t_dp_cmd                   i_cmd,
    output t_dp_status                o_status,
    output logic                      o_found,
    output logic [POS_W-1:0]          o_position
);

    logic [INDEX_W-1:0]        r_last_index;
    logic signed [VALUE_W-1:0] r_key;
    logic [SPAN_W-1:0]         r_low;
    logic [SPAN_W-1:0]         r_hp1;
    logic [ADDR_W-1:0]         r_mid;
    logic                      r_held_found;
    logic [POS_W-1:0]          r_held_pos;
    logic                      r_found;
    logic [POS_W-1:0]          r_position;

    logic [SPAN_W-1:0]  hp1_start;
    logic [ADDR_W-1:0]  start_mid;
    logic [SPAN_W-1:0]  mid_ext;
    logic [SPAN_W-1:0]  mid_p1;
    logic [SUM_W-1:0]   sum_lt;
    logic [SUM_W-1:0]   sum_gt;
    logic [ADDR_W-1:0]  next_mid;
    logic [ADDR_W-1:0]  rd_addr;
    logic [VALUE_W-1:0] rdata;
    logic               key_eq;
    logic               key_lt;
    logic               lt_more;
    logic               gt_more;
    logic               done;
    logic               wr_en;
    logic               res_found;
    logic [POS_W-1:0]   res_pos;

    assign wr_en = i_cmd.write && (int'(i_index) < TABLE_DEPTH);

    stbs_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (ADDR_W'(i_index)),
        .i_wdata (i_value),
        .i_raddr (rd_addr),
        .o_rdata (rdata)
    );

    // search range saturates at the table end
    always_comb begin
        if (int'(r_last_index) >= TABLE_DEPTH - 1) begin
            hp1_start = SPAN_W'(TABLE_DEPTH);
        end else begin
            hp1_start = SPAN_W'(r_last_index) + SPAN_W'(1);
        end
    end

    assign start_mid = ADDR_W'((hp1_start - SPAN_W'(1)) >> 1);

    assign mid_ext = SPAN_W'(r_mid);
    assign mid_p1  = mid_ext + SPAN_W'(1);
    assign key_eq  = (r_key == $signed(rdata));
    assign key_lt  = (r_key < $signed(rdata));
    assign lt_more = (r_low < mid_ext);
    assign gt_more = (mid_p1 < r_hp1);

    // both candidate midpoints in parallel with the compare
    assign sum_lt   = SUM_W'(r_low) + SUM_W'(mid_ext) - SUM_W'(1);
    assign sum_gt   = SUM_W'(mid_ext) + SUM_W'(r_hp1);
    assign next_mid = key_lt ? ADDR_W'(sum_lt >> 1) : ADDR_W'(sum_gt >> 1);
    assign rd_addr  = i_cmd.start ? start_mid : next_mid;

    assign done      = key_eq || (key_lt ? !lt_more : !gt_more);
    assign res_found = key_eq;
    assign res_pos   = key_eq ? POS_W'(r_mid) : '0;

    assign o_status.done = done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_index <= '0;
        end else if (i_cfg_we) begin
            r_last_index <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_key <= i_value;
            r_low <= '0;
            r_hp1 <= hp1_start;
        end else if (i_cmd.step) begin
            if (key_lt) begin
                r_hp1 <= mid_ext;
            end else begin
                r_low <= mid_p1;
            end
        end
        if (i_cmd.start || i_cmd.step) begin
            r_mid <= rd_addr;
        end
        if (i_cmd.hold_result) begin
            r_held_found <= res_found;
            r_held_pos   <= res_pos;
        end
        if (i_cmd.load_out) begin
            r_found    <= i_cmd.out_from_held ? r_held_found : res_found;
            r_position <= i_cmd.out_from_held ? r_held_pos : res_pos;
        end
    end

    assign o_found    = r_found;
    assign o_position = r_position;

    // a probe that does not finish leaves a non-empty range behind
    a_range_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && !done) |=> (r_low < r_hp1))
        else $error("range empty after continuing probe");

endmodule

### design/stbs_ctrl.sv
module stbs_ctrl
    import stbs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_command,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output logic       o_out_valid,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_HOLD = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   accept;
    logic   out_free;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        n_state             = r_state;
        o_cmd               = '0;
        o_cmd.start         = accept && (i_command == CMD_SEARCH);
        o_cmd.write         = accept && (i_command == CMD_WRITE);
        case (r_state)
            S_IDLE: begin
                if (o_cmd.start) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                o_cmd.step = 1'b1;
                if (i_status.done) begin
                    if (out_free) begin
                        o_cmd.load_out = 1'b1;
                        n_state        = S_IDLE;
                    end else begin
                        o_cmd.hold_result = 1'b1;
                        n_state           = S_HOLD;
                    end
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    o_cmd.load_out      = 1'b1;
                    o_cmd.out_from_held = 1'b1;
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> out_free)
        else $error("output register overwritten before transfer");

    a_search_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |=> (r_state == S_RUN))
        else $error("search did not start probing");

    a_hold_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_HOLD) && !out_free) |=> (r_state == S_HOLD))
        else $error("held result dropped");

endmodule

### design/sorted_table_binary_search_unit.sv
// Binary search over a table of signed 32-bit entries written in ascending
// order. A write transfer (command 0) stores one entry at i_index; a search
// transfer (command 1) bisects entries 0..last_index and returns the first
// probed index that matches, or found = 0 with position 0. A search issues
// the first table read when it is accepted and then makes
// at most log2(TABLE_DEPTH)+1 probes of the table; the
// registered read port of the table memory sets one probe per cycle. Input
// is taken again as soon as the last probe is done; the result sits in an
// output register, and if that register is still full the result is parked
// and input waits until it drains. Write last_index only while no search is
// in flight. Searching an entry never written gives an undefined answer.
module sorted_table_binary_search_unit
    import stbs_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [INDEX_W-1:0]        i_cfg_wdata,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_command,
    input  logic [INDEX_W-1:0]        i_index,
    input  logic signed [VALUE_W-1:0] i_value,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic                      o_found,
    output logic [POS_W-1:0]          o_position
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    stbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_command   (i_command),
        .i_out_ready (i_out_ready),
        .i_status    (dp_status),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (dp_cmd)
    );

    stbs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_index     (i_index),
        .i_value     (i_value),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .o_found     (o_found),
        .o_position  (o_position)
    );

endmodule
